[rtl/lcr_pkg.sv]
// Shared types and constants for the load-cell converter serial reader.
// No dependencies; every other file refers to it by scoped names.
package lcr_pkg;

  // Default converter word length
  localparam int DataBitsDef = 24;

  // Field and register widths
  localparam int HalfW    = 16;
  localparam int TareW    = 24;
  localparam int RatioW   = 16;
  localparam int RawW     = 24;
  localparam int WeightW  = 40;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;

  // Register values after reset
  localparam logic [HalfW-1:0]         HalfReset  = 16'd10;
  localparam logic [TareW-1:0]         TareReset  = 24'd0;
  localparam logic signed [RatioW-1:0] RatioReset = 16'sd1;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HALF_PERIOD = 2'd0,
    CFG_TARE        = 2'd1,
    CFG_RATIO       = 2'd2
  } cfg_idx_e;

  // Readout sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SETTLE = 3'd1,
    PH_WAIT   = 3'd2,
    PH_HIGH   = 3'd3,
    PH_LOW    = 3'd4,
    PH_XHIGH  = 3'd5,
    PH_XLOW   = 3'd6
  } phase_e;

  // Per-tick status from the sequencer to the scaling stages
  typedef struct packed {
    logic sck;
    logic busy;
    logic done;
  } seq_ctl_t;

endpackage

[rtl/lcr_if.sv]
// Valid/ready channel interfaces for the serial reader: tick samples in, results out.
// Depends on lcr_pkg for field widths.
interface lcr_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic dout_level;

  modport source (output valid, output start_req, output dout_level, input ready);
  modport sink   (input valid, input start_req, input dout_level, output ready);
endinterface

interface lcr_out_if;
  logic                             valid;
  logic                             ready;
  logic                             sck_level;
  logic                             busy_res;
  logic                             done_res;
  logic [lcr_pkg::RawW-1:0]         raw_reading;
  logic signed [lcr_pkg::WeightW-1:0] weight;

  modport source (output valid, output sck_level, output busy_res, output done_res,
                  output raw_reading, output weight, input ready);
  modport sink   (input valid, input sck_level, input busy_res, input done_res,
                  input raw_reading, input weight, output ready);
endinterface

[rtl/lcr_seq.sv]
// Readout sequencer: clock generation, ready wait and bit capture, one tick per step.
// Depends on lcr_pkg (phase_e, seq_ctl_t, widths).
module lcr_seq #(
  parameter int DataBits = lcr_pkg::DataBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic                      adv_i,
  input  logic                      start_i,
  input  logic                      dout_i,
  input  logic [lcr_pkg::HalfW-1:0] half_period_i,
  output logic                      res_valid_o,
  output lcr_pkg::seq_ctl_t         ctl_o,
  output logic [DataBits-1:0]       raw_o
);

  localparam int BitCntW = $clog2(DataBits + 1);
  localparam logic [DataBits-1:0] SignFlip = {1'b1, {(DataBits-1){1'b0}}};

  lcr_pkg::phase_e           phase_q, phase_d;
  logic [lcr_pkg::HalfW-1:0] tick_q, tick_d, tick_inc;
  logic [BitCntW-1:0]        bit_q, bit_d, bit_inc;
  logic [DataBits-1:0]       shift_q, shift_d;
  logic                      sck_q, sck_d;
  logic                      elapsed;
  logic                      step;
  logic                      res_valid_q;
  lcr_pkg::seq_ctl_t         ctl_q, ctl_d;
  logic [DataBits-1:0]       raw_q, raw_d;

  assign step = valid_i & adv_i;

  // Half-period counter; a zero setting acts as one tick
  assign tick_inc = tick_q + 1'b1;
  assign elapsed  = (tick_inc >= half_period_i) || (tick_inc == '0);
  assign bit_inc  = bit_q + 1'b1;

  // Next state and per-tick result
  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    sck_d   = sck_q;
    raw_d   = '0;
    ctl_d   = '0;
    case (phase_q)
      lcr_pkg::PH_IDLE: begin
        if (start_i) begin
          phase_d = lcr_pkg::PH_SETTLE;
          tick_d  = '0;
          bit_d   = '0;
          shift_d = '0;
          sck_d   = 1'b0;
        end
      end
      lcr_pkg::PH_SETTLE: begin
        tick_d = elapsed ? '0 : tick_inc;
        if (elapsed) phase_d = lcr_pkg::PH_WAIT;
      end
      lcr_pkg::PH_WAIT: begin
        if (!dout_i) begin
          phase_d = lcr_pkg::PH_HIGH;
          sck_d   = 1'b1;
          tick_d  = '0;
        end
      end
      lcr_pkg::PH_HIGH: begin
        tick_d = elapsed ? '0 : tick_inc;
        if (elapsed) begin
          phase_d = lcr_pkg::PH_LOW;
          sck_d   = 1'b0;
        end
      end
      lcr_pkg::PH_LOW: begin
        tick_d = elapsed ? '0 : tick_inc;
        if (elapsed) begin
          shift_d = {shift_q[DataBits-2:0], dout_i};
          bit_d   = bit_inc;
          sck_d   = 1'b1;
          phase_d = (bit_inc >= BitCntW'(DataBits)) ? lcr_pkg::PH_XHIGH : lcr_pkg::PH_HIGH;
        end
      end
      lcr_pkg::PH_XHIGH: begin
        tick_d = elapsed ? '0 : tick_inc;
        if (elapsed) begin
          phase_d = lcr_pkg::PH_XLOW;
          sck_d   = 1'b0;
        end
      end
      lcr_pkg::PH_XLOW: begin
        tick_d = elapsed ? '0 : tick_inc;
        if (elapsed) begin
          phase_d   = lcr_pkg::PH_IDLE;
          ctl_d.done = 1'b1;
          raw_d     = shift_q ^ SignFlip;
        end
      end
      default: begin
        phase_d = lcr_pkg::PH_IDLE;
        sck_d   = 1'b0;
      end
    endcase
    ctl_d.sck  = sck_d;
    ctl_d.busy = (phase_d != lcr_pkg::PH_IDLE);
  end

  // Advance the sequencer only on an accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lcr_pkg::PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      sck_q   <= 1'b0;
    end else if (step) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      sck_q   <= sck_d;
    end
  end

  // Result stage: hold while the next stage is full
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      ctl_q       <= '0;
    end else if (adv_i) begin
      res_valid_q <= valid_i;
      ctl_q       <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      raw_q <= raw_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign ctl_o       = ctl_q;
  assign raw_o       = raw_q;

  // Checks
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && ctl_q.done |-> !ctl_q.busy)
    else $error("done reported while still busy");

  a_sck_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && ctl_q.sck |-> ctl_q.busy)
    else $error("serial clock high outside a reading");

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= BitCntW'(DataBits))
    else $error("bit counter past word length");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(phase_q) && $stable(shift_q))
    else $error("sequencer moved without an accepted tick");

endmodule

[rtl/lcr_scale.sv]
// Tare subtraction and gain stages, ending in the output register of the result channel.
// Depends on lcr_pkg (seq_ctl_t, widths) and lcr_if.
module lcr_scale #(
  parameter int DataBits = lcr_pkg::DataBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  lcr_pkg::seq_ctl_t                 ctl_i,
  input  logic [DataBits-1:0]               raw_i,
  input  logic [lcr_pkg::TareW-1:0]         tare_i,
  input  logic signed [lcr_pkg::RatioW-1:0] ratio_i,
  lcr_out_if.source                         result_o
);

  localparam int MagW  = (DataBits > lcr_pkg::TareW) ? DataBits : lcr_pkg::TareW;
  localparam int DiffW = MagW + 1;
  localparam int ProdW = DiffW + lcr_pkg::RatioW;

  logic                          en1, en2;
  logic                          v1_q, v2_q;
  lcr_pkg::seq_ctl_t             ctl1_q, ctl2_q;
  logic [lcr_pkg::RawW-1:0]      raw1_q, raw1_d, raw2_q;
  logic signed [DiffW-1:0]       diff_q, diff_d;
  logic signed [ProdW-1:0]       prod;
  logic signed [lcr_pkg::WeightW-1:0] weight_q;

  assign en2     = !v2_q || result_o.ready;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  // Tared reading; zero unless this beat completes a reading
  always_comb begin
    diff_d = '0;
    raw1_d = '0;
    if (ctl_i.done) begin
      diff_d = $signed({1'b0, MagW'(raw_i)}) - $signed({1'b0, MagW'(tare_i)});
      raw1_d = lcr_pkg::RawW'(raw_i);
    end
  end

  assign prod = diff_q * ratio_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      ctl1_q <= '0;
      v2_q   <= 1'b0;
      ctl2_q <= '0;
    end else begin
      if (en1) begin
        v1_q   <= valid_i;
        ctl1_q <= ctl_i;
      end
      if (en2) begin
        v2_q   <= v1_q;
        ctl2_q <= ctl1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      diff_q <= diff_d;
      raw1_q <= raw1_d;
    end
    if (en2) begin
      raw2_q   <= raw1_q;
      weight_q <= prod[lcr_pkg::WeightW-1:0];
    end
  end

  assign result_o.valid       = v2_q;
  assign result_o.sck_level   = ctl2_q.sck;
  assign result_o.busy_res    = ctl2_q.busy;
  assign result_o.done_res    = ctl2_q.done;
  assign result_o.raw_reading = raw2_q;
  assign result_o.weight      = weight_q;

  // Checks
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !ctl2_q.done |-> (raw2_q == '0) && (weight_q == '0))
    else $error("result fields set on a beat without done");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !result_o.ready |=> v2_q && $stable(weight_q) && $stable(ctl2_q))
    else $error("stalled result changed");

endmodule

[rtl/load_cell_adc_serial_reader.sv]
// Top level of the load-cell converter serial reader: config registers, input stage,
// sequencer (lcr_seq) and scaling stages (lcr_scale). Depends on lcr_pkg and lcr_if.
//
//   port       | dir | handshake     | payload
//   -----------+-----+---------------+---------------------------------------------
//   sample_i   | in  | valid/ready   | start_req, dout_level (one timer tick)
//   result_o   | out | valid/ready   | sck_level, busy_res, done_res, raw_reading, weight
//   cfg_*_i    | in  | write enable  | cfg_idx_i, cfg_data_i
//
// One tick beat is taken per cycle unless stalled; each gives exactly one result beat
// via input register, sequencer step, tare subtract, gain multiply into the output register.
// The sequencer advances one phase step per accepted tick; throughput is set by it.
// Reset clears the sequencer to idle and loads half period 10, tare 0, ratio 1.
// A stalled result holds every stage; ready back to the source follows the stage fill.
module load_cell_adc_serial_reader #(
  parameter int DataBits = lcr_pkg::DataBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lcr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lcr_pkg::CfgDataW-1:0] cfg_data_i,
  lcr_in_if.sink                       sample_i,
  lcr_out_if.source                    result_o
);

  logic [lcr_pkg::HalfW-1:0]         half_q;
  logic [lcr_pkg::TareW-1:0]         tare_q;
  logic signed [lcr_pkg::RatioW-1:0] ratio_q;

  logic              in_v_q, in_start_q, in_dout_q;
  logic              en_in, en_seq;
  logic              seq_v;
  lcr_pkg::seq_ctl_t seq_ctl;
  logic [DataBits-1:0] seq_raw;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q  <= lcr_pkg::HalfReset;
      tare_q  <= lcr_pkg::TareReset;
      ratio_q <= lcr_pkg::RatioReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lcr_pkg::CFG_HALF_PERIOD: half_q  <= cfg_data_i[lcr_pkg::HalfW-1:0];
        lcr_pkg::CFG_TARE:        tare_q  <= cfg_data_i[lcr_pkg::TareW-1:0];
        lcr_pkg::CFG_RATIO:       ratio_q <= $signed(cfg_data_i[lcr_pkg::RatioW-1:0]);
        default: ;
      endcase
    end
  end

  // Input register
  assign en_in          = !in_v_q || en_seq;
  assign sample_i.ready = en_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (en_in) begin
      in_v_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_in) begin
      in_start_q <= sample_i.start_req;
      in_dout_q  <= sample_i.dout_level;
    end
  end

  lcr_seq #(.DataBits(DataBits)) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_v_q),
    .adv_i         (en_seq),
    .start_i       (in_start_q),
    .dout_i        (in_dout_q),
    .half_period_i (half_q),
    .res_valid_o   (seq_v),
    .ctl_o         (seq_ctl),
    .raw_o         (seq_raw)
  );

  // The sequencer's result register advances when the scaling stages have room
  lcr_scale #(.DataBits(DataBits)) u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (seq_v),
    .ready_o  (en_seq),
    .ctl_i    (seq_ctl),
    .raw_i    (seq_raw),
    .tare_i   (tare_q),
    .ratio_i  (ratio_q),
    .result_o (result_o)
  );

  // Checks
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_v_q && !en_seq |=> in_v_q && $stable(in_start_q) && $stable(in_dout_q))
    else $error("input register lost a waiting tick");

endmodule

[test/tb_top.sv]
// Self-checking bench for the load-cell converter serial reader: drives timer ticks,
// predicts each result beat, and compares it field by field.
// Depends on lcr_pkg, lcr_if and the load_cell_adc_serial_reader top level.
module tb_top;

  // One result beat as seen on the result channel
  typedef struct packed {
    logic                               sck;
    logic                               busy;
    logic                               done;
    logic [lcr_pkg::RawW-1:0]           raw;
    logic signed [lcr_pkg::WeightW-1:0] weight;
  } tick_res_t;

  // Directed stimulus row: one tick repeated, the last one optionally with a typed result
  typedef struct {
    logic        start;
    logic        dout;
    logic        dout_rnd;
    int unsigned reps;
    logic        typed;
    tick_res_t   res;
  } dir_row_t;

  // Random phase: register setting, idling mix and how long to run
  typedef struct {
    logic [lcr_pkg::HalfW-1:0]  half;
    logic [lcr_pkg::TareW-1:0]  tare;
    logic [lcr_pkg::RatioW-1:0] ratio;
    logic                       rnd_gain;
    int unsigned                send_idle;
    int unsigned                recv_stall;
    int unsigned                min_ticks;
    int unsigned                min_reads;
    logic                       long_hold;
  } rand_phase_t;

  // Shape of the data bits offered during one reading
  typedef enum logic [1:0] {
    PAT_RANDOM,
    PAT_ZEROS,
    PAT_ONES
  } bit_pat_e;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [lcr_pkg::CfgIdxW-1:0]   cfg_idx;
  logic [lcr_pkg::CfgDataW-1:0]  cfg_data;

  lcr_in_if  in_bus ();
  lcr_out_if out_bus ();

  load_cell_adc_serial_reader u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .sample_i   (in_bus),
    .result_o   (out_bus)
  );

  always #2 clk = ~clk;

  // Predictor copy of the sequencer and the registers
  lcr_pkg::phase_e                    seq_phase;
  logic [15:0]                        tick_cnt;
  int unsigned                        bit_cnt;
  logic [lcr_pkg::RawW-1:0]           shift_word;
  logic                               sck_q;
  logic [lcr_pkg::HalfW-1:0]          half_cfg;
  logic [lcr_pkg::TareW-1:0]          tare_cfg;
  logic signed [lcr_pkg::RatioW-1:0]  ratio_cfg;

  tick_res_t   pending_res[$];
  tick_res_t   mon_want;
  dir_row_t    dir_tab[$];
  rand_phase_t phase_tab[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          long_hold_req  = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned fails          = 0;
  int unsigned ticks_sent     = 0;
  int unsigned reads_done     = 0;
  int unsigned settings_used  = 0;

  // Count one half period; true when it has run out (zero behaves as one tick)
  function automatic bit half_elapsed();
    tick_cnt = tick_cnt + 16'd1;
    if (tick_cnt >= half_cfg || tick_cnt == 16'd0) begin
      tick_cnt = 16'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the predicted sequencer by one tick and form its result beat
  function automatic tick_res_t adc_readout_step(logic start, logic dout);
    tick_res_t r;
    longint    diff;
    longint    prod;
    r = '0;
    case (seq_phase)
      lcr_pkg::PH_IDLE: begin
        if (start) begin
          seq_phase  = lcr_pkg::PH_SETTLE;
          tick_cnt   = '0;
          bit_cnt    = 0;
          shift_word = '0;
          sck_q      = 1'b0;
        end
      end
      lcr_pkg::PH_SETTLE: begin
        if (half_elapsed()) seq_phase = lcr_pkg::PH_WAIT;
      end
      lcr_pkg::PH_WAIT: begin
        if (!dout) begin
          seq_phase = lcr_pkg::PH_HIGH;
          sck_q     = 1'b1;
          tick_cnt  = '0;
        end
      end
      lcr_pkg::PH_HIGH: begin
        if (half_elapsed()) begin
          seq_phase = lcr_pkg::PH_LOW;
          sck_q     = 1'b0;
        end
      end
      lcr_pkg::PH_LOW: begin
        if (half_elapsed()) begin
          shift_word = {shift_word[lcr_pkg::RawW-2:0], dout};
          bit_cnt++;
          sck_q     = 1'b1;
          seq_phase = (bit_cnt >= lcr_pkg::DataBitsDef) ? lcr_pkg::PH_XHIGH
                                                        : lcr_pkg::PH_HIGH;
        end
      end
      lcr_pkg::PH_XHIGH: begin
        if (half_elapsed()) begin
          seq_phase = lcr_pkg::PH_XLOW;
          sck_q     = 1'b0;
        end
      end
      lcr_pkg::PH_XLOW: begin
        if (half_elapsed()) begin
          seq_phase = lcr_pkg::PH_IDLE;
          r.done    = 1'b1;
          r.raw     = shift_word ^ 24'h80_0000;
          diff      = longint'(r.raw) - longint'(tare_cfg);
          prod      = diff * longint'(ratio_cfg);
          r.weight  = prod[lcr_pkg::WeightW-1:0];
        end
      end
      default: begin
        seq_phase = lcr_pkg::PH_IDLE;
        sck_q     = 1'b0;
      end
    endcase
    r.sck  = sck_q;
    r.busy = (seq_phase != lcr_pkg::PH_IDLE);
    return r;
  endfunction

  function automatic tick_res_t mk_res(logic sck, logic busy, logic done,
                                       logic [lcr_pkg::RawW-1:0] raw,
                                       logic [lcr_pkg::WeightW-1:0] weight);
    tick_res_t r;
    r.sck    = sck;
    r.busy   = busy;
    r.done   = done;
    r.raw    = raw;
    r.weight = weight;
    return r;
  endfunction

  task automatic add_row(logic start, logic dout, logic rnd, int unsigned reps,
                         logic typed, tick_res_t res);
    dir_row_t row;
    row.start    = start;
    row.dout     = dout;
    row.dout_rnd = rnd;
    row.reps     = reps;
    row.typed    = typed;
    row.res      = res;
    dir_tab.push_back(row);
  endtask

  task automatic add_phase(logic [lcr_pkg::HalfW-1:0] half, logic [lcr_pkg::TareW-1:0] tare,
                           logic [lcr_pkg::RatioW-1:0] ratio, logic rnd_gain,
                           int unsigned send_idle, int unsigned recv_stall,
                           int unsigned min_ticks, int unsigned min_reads, logic long_hold);
    rand_phase_t ph;
    ph.half       = half;
    ph.tare       = tare;
    ph.ratio      = ratio;
    ph.rnd_gain   = rnd_gain;
    ph.send_idle  = send_idle;
    ph.recv_stall = recv_stall;
    ph.min_ticks  = min_ticks;
    ph.min_reads  = min_reads;
    ph.long_hold  = long_hold;
    phase_tab.push_back(ph);
  endtask

  // Write all three registers back to back; call only while nothing is in flight
  task automatic write_regs(logic [lcr_pkg::HalfW-1:0] half, logic [lcr_pkg::TareW-1:0] tare,
                            logic [lcr_pkg::RatioW-1:0] ratio);
    logic [7:0] pad_a;
    logic [7:0] pad_b;
    pad_a = 8'($urandom);
    pad_b = 8'($urandom);
    cfg_we   <= 1'b1;
    cfg_idx  <= lcr_pkg::CFG_HALF_PERIOD;
    cfg_data <= {pad_a, half};
    @(posedge clk);
    cfg_idx  <= lcr_pkg::CFG_TARE;
    cfg_data <= tare;
    @(posedge clk);
    cfg_idx  <= lcr_pkg::CFG_RATIO;
    cfg_data <= {pad_b, ratio};
    @(posedge clk);
    cfg_we    <= 1'b0;
    half_cfg  = half;
    tare_cfg  = tare;
    ratio_cfg = ratio;
    settings_used++;
  endtask

  // Offer one tick beat, hold it until taken, then record what it should produce
  task automatic send_tick(logic start, logic dout, logic typed, tick_res_t typed_res);
    tick_res_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.start_req  <= start;
    in_bus.dout_level <= dout;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    pred = adc_readout_step(start, dout);
    pending_res.push_back(typed ? typed_res : pred);
    ticks_sent++;
    if (pred.done) reads_done++;
  endtask

  // Drop valid and let every pending result beat come out
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        hold_left     = 400;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare each result beat with the oldest pending one
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_res.size() == 0) begin
        fails++;
        $error("result beat with no pending tick");
      end else begin
        mon_want = pending_res.pop_front();
        if (out_bus.sck_level !== mon_want.sck) begin
          fails++;
          $error("sck_level: expected %0d, got %0d", mon_want.sck, out_bus.sck_level);
        end
        if (out_bus.busy_res !== mon_want.busy) begin
          fails++;
          $error("busy_res: expected %0d, got %0d", mon_want.busy, out_bus.busy_res);
        end
        if (out_bus.done_res !== mon_want.done) begin
          fails++;
          $error("done_res: expected %0d, got %0d", mon_want.done, out_bus.done_res);
        end
        if (out_bus.raw_reading !== mon_want.raw) begin
          fails++;
          $error("raw_reading: expected %h, got %h", mon_want.raw, out_bus.raw_reading);
        end
        if (out_bus.weight !== mon_want.weight) begin
          fails++;
          $error("weight: expected %0d, got %0d", mon_want.weight, out_bus.weight);
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain
  initial begin
    tick_res_t   no_res;
    tick_res_t   idle_res;
    dir_row_t    row;
    rand_phase_t ph;
    bit_pat_e    pat;
    logic        s;
    logic        d;
    logic [lcr_pkg::TareW-1:0]  tare_v;
    logic [lcr_pkg::RatioW-1:0] ratio_v;
    int unsigned ph_ticks;
    int unsigned ph_reads0;

    in_bus.valid      = 1'b0;
    in_bus.start_req  = 1'b0;
    in_bus.dout_level = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = lcr_pkg::CFG_HALF_PERIOD;
    cfg_data          = '0;
    rst_n             = 1'b0;

    seq_phase  = lcr_pkg::PH_IDLE;
    tick_cnt   = '0;
    bit_cnt    = 0;
    shift_word = '0;
    sck_q      = 1'b0;
    half_cfg   = lcr_pkg::HalfReset;
    tare_cfg   = lcr_pkg::TareReset;
    ratio_cfg  = lcr_pkg::RatioReset;
    pat        = PAT_RANDOM;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed readings run at a one-tick half period, tare 0, gain 1
    write_regs(16'd1, 24'd0, 16'd1);

    no_res   = '0;
    idle_res = mk_res(1'b0, 1'b0, 1'b0, '0, '0);
    // idle right after reset, data pin low is ignored
    add_row(1'b0, 1'b0, 1'b0, 3, 1'b1, idle_res);
    add_row(1'b1, 1'b1, 1'b0, 1, 1'b1, mk_res(1'b0, 1'b1, 1'b0, '0, '0));
    // start while busy is ignored through settle and the ready wait
    add_row(1'b1, 1'b1, 1'b0, 1, 1'b1, mk_res(1'b0, 1'b1, 1'b0, '0, '0));
    add_row(1'b1, 1'b1, 1'b0, 4, 1'b1, mk_res(1'b0, 1'b1, 1'b0, '0, '0));
    add_row(1'b0, 1'b0, 1'b0, 1, 1'b1, mk_res(1'b1, 1'b1, 1'b0, '0, '0));
    // all-ones word: clock ends high entering the extra pulse
    add_row(1'b0, 1'b1, 1'b0, 48, 1'b1, mk_res(1'b1, 1'b1, 1'b0, '0, '0));
    add_row(1'b0, 1'b1, 1'b0, 1, 1'b1, mk_res(1'b0, 1'b1, 1'b0, '0, '0));
    // completing tick carries a start that must not be taken
    add_row(1'b1, 1'b1, 1'b0, 1, 1'b1,
            mk_res(1'b0, 1'b0, 1'b1, 24'h7F_FFFF, 40'h00_007F_FFFF));
    add_row(1'b0, 1'b0, 1'b0, 1, 1'b1, idle_res);
    // all-zeros word, data pin already low during settle
    add_row(1'b1, 1'b0, 1'b0, 1, 1'b1, mk_res(1'b0, 1'b1, 1'b0, '0, '0));
    add_row(1'b0, 1'b0, 1'b0, 1, 1'b0, no_res);
    add_row(1'b0, 1'b0, 1'b0, 1, 1'b1, mk_res(1'b1, 1'b1, 1'b0, '0, '0));
    add_row(1'b0, 1'b0, 1'b0, 50, 1'b1,
            mk_res(1'b0, 1'b0, 1'b1, 24'h80_0000, 40'h00_0080_0000));
    // random word, start high at the outset and again through the data bits
    add_row(1'b1, 1'b0, 1'b0, 1, 1'b0, no_res);
    add_row(1'b0, 1'b0, 1'b0, 2, 1'b0, no_res);
    add_row(1'b1, 1'b0, 1'b1, 50, 1'b0, no_res);
    add_row(1'b0, 1'b1, 1'b0, 3, 1'b1, idle_res);

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      for (int unsigned k = 0; k < row.reps; k++) begin
        d = row.dout_rnd ? 1'($urandom_range(1)) : row.dout;
        send_tick(row.start, d, row.typed && (k == row.reps - 1), row.res);
      end
    end

    // half, tare, ratio, random gain, send idle %, recv stall %, ticks, readings, hold
    add_phase(16'd1,     24'h00_0000, 16'h0001, 1'b0, 0,  0,  50,  3, 1'b0);
    add_phase(16'd0,     24'hFF_FFFF, 16'h8000, 1'b0, 62, 0,  50,  3, 1'b0);
    add_phase(16'd2,     24'h80_0000, 16'h7FFF, 1'b0, 0,  62, 50,  1, 1'b0);
    add_phase(16'd1,     24'h00_0000, 16'h0000, 1'b1, 17, 17, 50,  4, 1'b1);
    add_phase(16'd3,     24'h00_0000, 16'hFFFF, 1'b0, 0,  0,  50,  1, 1'b0);
    add_phase(16'd65535, 24'h12_3456, 16'h0007, 1'b0, 17, 17, 80,  0, 1'b0);
    add_phase(16'd10,    24'h00_0000, 16'h0001, 1'b0, 0,  0,  80,  0, 1'b0);
    add_phase(16'd0,     24'h00_0000, 16'h0000, 1'b1, 62, 62, 50,  2, 1'b0);
    add_phase(16'd1,     24'h00_0000, 16'h8000, 1'b0, 0,  0,  50,  2, 1'b0);

    foreach (phase_tab[p]) begin
      ph = phase_tab[p];
      drain_results();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      tare_v  = ph.rnd_gain ? lcr_pkg::TareW'($urandom) : ph.tare;
      ratio_v = ph.rnd_gain ? lcr_pkg::RatioW'($urandom) : ph.ratio;
      write_regs(ph.half, tare_v, ratio_v);
      send_idle_pct  = ph.send_idle;
      recv_stall_pct = ph.recv_stall;
      if (ph.long_hold) long_hold_req = 1'b1;
      ph_ticks  = 0;
      ph_reads0 = reads_done;
      while (ph_ticks < ph.min_ticks || reads_done - ph_reads0 < ph.min_reads) begin
        // shape the tick from the predicted phase so most readings run to completion
        case (seq_phase)
          lcr_pkg::PH_IDLE: begin
            s = ($urandom_range(99) < 70);
            d = 1'($urandom_range(1));
            if (s) begin
              case ($urandom_range(3))
                0:       pat = PAT_ZEROS;
                1:       pat = PAT_ONES;
                default: pat = PAT_RANDOM;
              endcase
            end
          end
          lcr_pkg::PH_WAIT: begin
            s = ($urandom_range(99) < 20);
            d = ($urandom_range(99) >= 35);
          end
          default: begin
            s = ($urandom_range(99) < 20);
            case (pat)
              PAT_ZEROS: d = 1'b0;
              PAT_ONES:  d = 1'b1;
              default:   d = 1'($urandom_range(1));
            endcase
          end
        endcase
        send_tick(s, d, 1'b0, no_res);
        ph_ticks++;
      end
    end

    drain_results();
    repeat (12) @(posedge clk);

    $display("Drove %0d ticks over %0d register settings; %0d readings completed.",
             ticks_sent, settings_used, reads_done);
    $display("Half periods 0 to 65535, tare and gain at both ends, four idling mixes.");
    if (fails == 0 && pending_res.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #(4 * 400000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
